/* hw/rtl/led_matrix_bitplane_scanner_macros.svh */
// assertion macros for the led matrix bit-plane scanner checker
// expects clk_i and rst_ni to be visible where the macros are used
`ifndef LED_MATRIX_BITPLANE_SCANNER_MACROS_SVH
`define LED_MATRIX_BITPLANE_SCANNER_MACROS_SVH

// property checked at every clock edge outside reset
`define LMBS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// condition in one cycle implies a condition in the next
`define LMBS_ASSERT_NEXT(label, pre, post, msg) \
  `LMBS_ASSERT(label, (pre) |=> (post), msg)

`endif

/* hw/rtl/lmbs_pkg.sv */
// shared constants, register codes and structs of the bit-plane scanner
// no dependencies
`default_nettype none

package lmbs_pkg;

  localparam int unsigned PLANES   = 3;
  localparam int unsigned ROWS     = 16;
  localparam int unsigned COLUMNS  = 16;

  localparam int unsigned ENTRIES  = PLANES * ROWS;
  localparam int unsigned ADDR_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned PLANE_W  = 2;
  localparam int unsigned ROW_W    = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int unsigned FROW_W   = 4;
  localparam int unsigned COL_W    = 16;
  localparam int unsigned TICK_W   = 8;
  localparam int unsigned LIT_W    = 4;
  localparam int unsigned ON_TIMES = 3;

  localparam int unsigned APB_ADDR_W = 5;
  localparam int unsigned APB_DATA_W = 32;

  localparam logic [COL_W-1:0]  COL_MASK      = COL_W'((32'd1 << COLUMNS) - 32'd1);
  localparam logic [TICK_W-1:0] FIRST_COMPARE = 8'd20;
  localparam logic [TICK_W-1:0] ON_TIME_RESET [ON_TIMES] = '{8'd3, 8'd4, 8'd22};

  typedef enum logic [2:0] {
    REG_ON_TIME0 = 3'd0,
    REG_ON_TIME1 = 3'd1,
    REG_ON_TIME2 = 3'd2,
    REG_LIT_ROW  = 3'd3,
    REG_SCAN_EN  = 3'd4
  } reg_idx_e;

  // register contents plus one-cycle events from enable writes
  typedef struct packed {
    logic [ON_TIMES-1:0][TICK_W-1:0] on_time;
    logic [LIT_W-1:0]                lit_row;
    logic                            scan_en;
    logic                            restart;
    logic                            blank;
  } cfg_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [COL_W-1:0]  wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } ram_req_t;

  // per-transaction result of the counter stage
  typedef struct packed {
    logic               load;
    logic               entry_ok;
    logic [PLANE_W-1:0] plane;
    logic [ROW_W-1:0]   row;
    logic               led;
    logic               dummy;
    logic               frame;
  } scan_res_t;

endpackage

`default_nettype wire

/* hw/rtl/lmbs_ram.sv */
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
`default_nettype none

module lmbs_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 48
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* hw/rtl/lmbs_regs.sv */
// apb register file: plane on-times, lit row, scan enable
// depends on lmbs_pkg
`default_nettype none

module lmbs_regs
  import lmbs_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic      [APB_DATA_W-1:0] prdata,
  output logic                       pready,
  output cfg_t                       cfg_o
);

  logic [ON_TIMES-1:0][TICK_W-1:0] on_time_q, on_time_d;
  logic [LIT_W-1:0]                lit_row_q, lit_row_d;
  logic                            scan_en_q, scan_en_d;
  logic                            wr_en;
  reg_idx_e                        idx;

  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_idx_e'(paddr[APB_ADDR_W-1:2]);
  assign pready = 1'b1;

  always_comb begin
    on_time_d = on_time_q;
    lit_row_d = lit_row_q;
    scan_en_d = scan_en_q;
    if (wr_en) begin
      case (idx)
        REG_ON_TIME0: on_time_d[0] = pwdata[TICK_W-1:0];
        REG_ON_TIME1: on_time_d[1] = pwdata[TICK_W-1:0];
        REG_ON_TIME2: on_time_d[2] = pwdata[TICK_W-1:0];
        REG_LIT_ROW:  lit_row_d    = pwdata[LIT_W-1:0];
        REG_SCAN_EN:  scan_en_d    = pwdata[0];
        default:      ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_ON_TIME0: prdata = APB_DATA_W'(on_time_q[0]);
      REG_ON_TIME1: prdata = APB_DATA_W'(on_time_q[1]);
      REG_ON_TIME2: prdata = APB_DATA_W'(on_time_q[2]);
      REG_LIT_ROW:  prdata = APB_DATA_W'(lit_row_q);
      REG_SCAN_EN:  prdata = APB_DATA_W'(scan_en_q);
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ON_TIMES; i++) begin
        on_time_q[i] <= ON_TIME_RESET[i];
      end
      lit_row_q <= '0;
      scan_en_q <= 1'b1;
    end else begin
      on_time_q <= on_time_d;
      lit_row_q <= lit_row_d;
      scan_en_q <= scan_en_d;
    end
  end

  always_comb begin
    cfg_o.on_time = on_time_q;
    cfg_o.lit_row = lit_row_q;
    cfg_o.scan_en = scan_en_q;
    // re-enable restarts the tick counter, disable blanks the columns
    cfg_o.restart = wr_en && (idx == REG_SCAN_EN) && pwdata[0] && !scan_en_q;
    cfg_o.blank   = wr_en && (idx == REG_SCAN_EN) && !pwdata[0];
  end

endmodule

`default_nettype wire

/* hw/rtl/lmbs_scan.sv */
// tick counter, plane and row sequencer, frame store request and entry valid bits
// depends on lmbs_pkg
`default_nettype none

module lmbs_scan
  import lmbs_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               accept_i,
  input  wire logic               kind_i,
  input  wire logic [PLANE_W-1:0] wr_plane_i,
  input  wire logic [FROW_W-1:0]  wr_row_i,
  input  wire logic [COL_W-1:0]   wr_bits_i,
  input  wire cfg_t               cfg_i,
  output ram_req_t                ram_req_o,
  output scan_res_t               res_o
);

  localparam int unsigned PI_W  = PLANE_W + 1;
  localparam int unsigned RI_W  = ROW_W + 1;
  localparam int unsigned CMP_W = ROW_W + LIT_W;

  logic [TICK_W-1:0]  tick_q, tick_d;
  logic [TICK_W-1:0]  cmp_q, cmp_d;
  logic [PLANE_W-1:0] plane_q, plane_d;
  logic [ROW_W-1:0]   row_q, row_d;
  logic               led_q, led_d;
  logic               dummy_q, dummy_d;
  logic [ENTRIES-1:0] valid_q, valid_d;

  logic               step, match, plane_wrap, row_wrap, wr_ok;
  logic [PI_W-1:0]    plane_inc;
  logic [RI_W-1:0]    row_inc;
  logic [ROW_W-1:0]   row_nx;
  logic [ADDR_W-1:0]  waddr, raddr;

  assign step       = accept_i && !kind_i && cfg_i.scan_en;
  assign match      = (tick_q == cmp_q);
  assign plane_inc  = PI_W'(plane_q) + PI_W'(1);
  assign plane_wrap = plane_inc >= PI_W'(PLANES);
  assign row_inc    = RI_W'(row_q) + RI_W'(1);
  assign row_wrap   = row_inc >= RI_W'(ROWS);
  assign row_nx     = row_wrap ? '0 : row_inc[ROW_W-1:0];

  assign wr_ok = accept_i && kind_i && (32'(wr_plane_i) < PLANES) && (32'(wr_row_i) < ROWS);
  assign waddr = ADDR_W'(ADDR_W'(wr_plane_i) * ADDR_W'(ROWS) + ADDR_W'(wr_row_i));
  assign raddr = ADDR_W'(ADDR_W'(plane_d) * ADDR_W'(ROWS) + ADDR_W'(row_d));

  always_comb begin
    tick_d  = tick_q;
    cmp_d   = cmp_q;
    plane_d = plane_q;
    row_d   = row_q;
    led_d   = led_q;
    dummy_d = dummy_q;
    valid_d = valid_q;
    if (cfg_i.restart) begin
      tick_d = '0;
      cmp_d  = FIRST_COMPARE;
    end
    if (step) begin
      if (match) begin
        tick_d = '0;
        if (plane_wrap) begin
          plane_d = '0;
          row_d   = row_nx;
          led_d   = (CMP_W'(row_nx) == CMP_W'(cfg_i.lit_row));
          dummy_d = !led_d;
        end else begin
          plane_d = plane_inc[PLANE_W-1:0];
        end
        cmp_d = cfg_i.on_time[plane_d];
      end else begin
        tick_d = tick_q + TICK_W'(1);
      end
    end
    if (wr_ok) begin
      valid_d[waddr] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q  <= '0;
      cmp_q   <= FIRST_COMPARE;
      plane_q <= '0;
      row_q   <= '0;
      led_q   <= 1'b0;
      dummy_q <= 1'b0;
      valid_q <= '0;
    end else begin
      tick_q  <= tick_d;
      cmp_q   <= cmp_d;
      plane_q <= plane_d;
      row_q   <= row_d;
      led_q   <= led_d;
      dummy_q <= dummy_d;
      valid_q <= valid_d;
    end
  end

  always_comb begin
    ram_req_o.we    = wr_ok;
    ram_req_o.waddr = waddr;
    ram_req_o.wdata = wr_bits_i & COL_MASK;
    ram_req_o.re    = step && match;
    ram_req_o.raddr = raddr;

    res_o.load     = step && match;
    // never-written entries read as zero
    res_o.entry_ok = valid_q[raddr];
    res_o.plane    = plane_d;
    res_o.row      = row_d;
    res_o.led      = led_d;
    res_o.dummy    = dummy_d;
    res_o.frame    = step && match && plane_wrap && row_wrap;
  end

endmodule

`default_nettype wire

/* hw/rtl/led_matrix_bitplane_scanner.sv */
// top level of the led matrix bit-plane scanner
// depends on lmbs_pkg, lmbs_regs, lmbs_scan, lmbs_ram
//
// usage
//   input channel: kind_i selects a timer tick (0) or a frame store write (1)
//   with wr_plane_i, wr_row_i, wr_bits_i. every input transaction produces
//   exactly one output transaction with the column levels, row driver
//   states, frame pulse and the plane and row now shown
//   pipeline: the result is registered from the counter stage into the
//   read stage, then into the output register. throughput is one
//   transaction per cycle unless stalled, set by the single frame store
//   read issued in the counter stage for a tick that matches
//   the stall: while the output register holds an unaccepted result the
//   read stage keeps its transaction and ram data; in_stall_o rises only
//   when both are full, so one result may wait while the next is taken
//   reset: counters and drivers clear, the compare value is 20, on-times
//   come up as 3, 4, 22. per-entry valid flops make the whole frame store
//   read as zero right after reset, no clearing pass is needed. the user
//   configures via the apb port with no transaction in flight (not enforced)
`default_nettype none

module led_matrix_bitplane_scanner
  import lmbs_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // input channel
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic                  kind_i,
  input  wire logic [PLANE_W-1:0]    wr_plane_i,
  input  wire logic [FROW_W-1:0]     wr_row_i,
  input  wire logic [COL_W-1:0]      wr_bits_i,
  // output channel
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic      [COL_W-1:0]      column_bits_o,
  output logic                       led_row_on_o,
  output logic                       dummy_row_on_o,
  output logic                       frame_done_o,
  output logic      [PLANE_W-1:0]    shown_plane_o,
  output logic      [FROW_W-1:0]     shown_row_o,
  // configuration port
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic      [APB_DATA_W-1:0] prdata,
  output logic                       pready
);

  cfg_t      cfg;
  ram_req_t  ram_req;
  scan_res_t scan_res;
  logic      accept;
  logic [COL_W-1:0] rdata;

  // read stage and output register
  logic             s1_valid_q, s1_valid_d;
  scan_res_t        s1_q;
  logic             s1_move;
  logic [COL_W-1:0] s1_col;
  logic [COL_W-1:0] column_q, column_d;

  logic               out_valid_q, out_valid_d;
  logic [COL_W-1:0]   out_col_q;
  logic               out_led_q, out_dummy_q, out_frame_q;
  logic [PLANE_W-1:0] out_plane_q;
  logic [ROW_W-1:0]   out_row_q;

  lmbs_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  lmbs_scan u_scan (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .kind_i     (kind_i),
    .wr_plane_i (wr_plane_i),
    .wr_row_i   (wr_row_i),
    .wr_bits_i  (wr_bits_i),
    .cfg_i      (cfg),
    .ram_req_o  (ram_req),
    .res_o      (scan_res)
  );

  // frame store: written by write transactions, read on a counter match.
  // a read is always issued in a later cycle than any earlier write,
  // so no forwarding is needed
  lmbs_ram #(
    .WIDTH (COL_W),
    .DEPTH (ENTRIES)
  ) u_frame_store (
    .clk_i   (clk_i),
    .we_i    (ram_req.we),
    .waddr_i (ram_req.waddr),
    .wdata_i (ram_req.wdata),
    .re_i    (ram_req.re),
    .raddr_i (ram_req.raddr),
    .rdata_o (rdata)
  );

  // read stage moves on when the output register is empty or draining
  assign s1_move    = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  // column levels: refreshed on a match, held otherwise
  always_comb begin
    if (s1_q.load) begin
      s1_col = s1_q.entry_ok ? (rdata & COL_MASK) : '0;
    end else begin
      s1_col = column_q;
    end
  end

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (s1_move) begin
      s1_valid_d = 1'b0;
    end

    out_valid_d = out_valid_q && out_stall_i;
    if (s1_move) begin
      out_valid_d = 1'b1;
    end

    column_d = column_q;
    if (cfg.blank) begin
      // disabling scan clears the held column levels at once
      column_d = '0;
    end else if (s1_move) begin
      column_d = s1_col;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      column_q    <= '0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      column_q    <= column_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q <= scan_res;
    end
    if (s1_move) begin
      out_col_q   <= s1_col;
      out_led_q   <= s1_q.led;
      out_dummy_q <= s1_q.dummy;
      out_frame_q <= s1_q.frame;
      out_plane_q <= s1_q.plane;
      out_row_q   <= s1_q.row;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign column_bits_o  = out_col_q;
  assign led_row_on_o   = out_led_q;
  assign dummy_row_on_o = out_dummy_q;
  assign frame_done_o   = out_frame_q;
  assign shown_plane_o  = out_plane_q;
  assign shown_row_o    = FROW_W'(out_row_q);

endmodule

`default_nettype wire

/* hw/rtl/lmbs_checker.sv */
// port-level checks of the bit-plane scanner, bound to the top level
// depends on lmbs_pkg and led_matrix_bitplane_scanner_macros.svh
`default_nettype none

`include "led_matrix_bitplane_scanner_macros.svh"

module lmbs_checker
  import lmbs_pkg::*;
(
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               out_valid_o,
  input wire logic               out_stall_i,
  input wire logic [COL_W-1:0]   column_bits_o,
  input wire logic               led_row_on_o,
  input wire logic               dummy_row_on_o,
  input wire logic               frame_done_o,
  input wire logic [PLANE_W-1:0] shown_plane_o,
  input wire logic [FROW_W-1:0]  shown_row_o
);

  // a stalled result stays offered and its column levels unchanged
  `LMBS_ASSERT_NEXT(a_stall_hold, out_valid_o && out_stall_i, out_valid_o && $stable(column_bits_o), "stalled result changed")

  // the two row drivers never conduct together in an offered result
  `LMBS_ASSERT(a_drivers_excl, !(out_valid_o && led_row_on_o && dummy_row_on_o), "both row drivers on")

  // a frame pulse comes only with the scan back at plane 0, row 0
  `LMBS_ASSERT(a_frame_origin, out_valid_o && frame_done_o |-> (shown_row_o == '0) && (shown_plane_o == '0), "frame pulse away from origin")

  // the shown plane stays below the plane count
  `LMBS_ASSERT(a_plane_range, out_valid_o |-> (32'(shown_plane_o) < PLANES), "plane index out of range")

endmodule

bind led_matrix_bitplane_scanner lmbs_checker u_lmbs_checker (.*);

`default_nettype wire
